@@ rtl/core/tsps_pkg.sv @@
package tsps_pkg;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_REQ_GPS  = 7'b0000010,
        PH_WAIT_GPS = 7'b0000100,
        PH_REQ_EAM  = 7'b0001000,
        PH_WAIT_EAM = 7'b0010000,
        PH_REQ_GAM  = 7'b0100000,
        PH_WAIT_GAM = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        K_SEND    = 3'd0,
        K_OK      = 3'd1,
        K_TIMEOUT = 3'd2,
        K_FONT    = 3'd3,
        K_SWITCH  = 3'd4
    } out_kind_t;

    typedef enum logic [2:0] {
        REG_WAIT_TIME  = 3'd0,
        REG_CLI_WINDOW = 3'd1,
        REG_GPS_LENGTH = 3'd2,
        REG_EAM_LENGTH = 3'd3,
        REG_GAM_LENGTH = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic        last;
        logic [15:0] tally;
        logic [1:0]  sensor;
        logic [7:0]  tx_byte;
        out_kind_t   out_kind;
    } result_t;

    localparam logic [1:0]  SENSOR_GPS = 2'd0;
    localparam logic [1:0]  SENSOR_EAM = 2'd1;
    localparam logic [1:0]  SENSOR_GAM = 2'd2;

    localparam logic [7:0]  REQ_BYTE   = 8'h80;
    localparam logic [7:0]  ADDR_GPS   = 8'h8a;
    localparam logic [7:0]  ADDR_EAM   = 8'h8e;
    localparam logic [7:0]  ADDR_GAM   = 8'h8d;
    localparam logic [7:0]  CHAR_LF    = 8'h0a;
    localparam logic [7:0]  CHAR_CR    = 8'h0d;
    localparam logic [7:0]  CRLF_TRIG  = 8'd3;

    localparam logic [15:0] WAIT_TIME_RST  = 16'd200;
    localparam logic [15:0] CLI_WINDOW_RST = 16'd20000;
    localparam logic [7:0]  GPS_LEN_RST    = 8'd55;
    localparam logic [7:0]  EAM_LEN_RST    = 8'd55;
    localparam logic [7:0]  GAM_LEN_RST    = 8'd57;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

@@ rtl/core/telemetry_sensor_poll_sequencer.sv @@
// Polling sequencer for a serial telemetry link.
// Input channel (s_): one word per event. s_tuser[0] = 0 is a millisecond
// tick, 1 is a byte received from the link, carried in s_tdata.
// Result channel (m_): send-byte, response ok/timeout, font upload and
// link-mode switch events; m_tlast marks the last result of an input word.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 wait_time, 1 cli_window, 2..4 GPS/electric/general response length).
// Write only while the block is idle.
// Latency: an input word's state update happens in the accept cycle and its
// results are visible on m_ from the next cycle on, behind any queued ones.
// Throughput: one input word per cycle when s_tready is high; each word
// yields zero to two results into a four-entry result queue; s_tready is
// high while the queue has room for two. Results leave at one per cycle
// when m_tready is high; the single read port limits two-result runs.
// Stall: when m_tready is low, results stay in the queue and s_tready drops
// once fewer than two entries are free; nothing is lost.
// Reset (aresetn low, synchronous): registers return to their defaults,
// timers, counters and tallies clear, the queue empties, phase goes idle.
module telemetry_sensor_poll_sequencer
    import tsps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [0:0]  s_tuser,    // [0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [2:0] out_kind, [10:3] tx_byte, [12:11] sensor,
                                    // [28:13] tally, [31:29] zero
    output logic        m_tlast,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] wait_time_reg;
    logic [15:0] cli_window_reg;
    logic [7:0]  gps_length_reg;
    logic [7:0]  eam_length_reg;
    logic [7:0]  gam_length_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] uptime_reg, uptime_next;
    logic [7:0]  rx_count_reg, rx_count_next;
    logic [7:0]  crlf_reg, crlf_next;
    logic [15:0] ok_reg [0:2];
    logic [15:0] ok_next [0:2];
    logic [15:0] fail_reg [0:2];
    logic [15:0] fail_next [0:2];

    result_t             queue_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    logic        s_acc, m_acc;
    logic        is_byte;
    logic        is_idle, is_req, is_wait;
    logic [1:0]  sen;
    logic [7:0]  addr_byte;
    logic [7:0]  resp_len;
    logic        font;
    logic [1:0]  mv_n;
    logic [1:0]  push_n;
    result_t     mv0, mv1;
    result_t     res0, res1;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign is_byte  = s_tuser[0];
    assign s_tready = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_time_reg  <= WAIT_TIME_RST;
            cli_window_reg <= CLI_WINDOW_RST;
            gps_length_reg <= GPS_LEN_RST;
            eam_length_reg <= EAM_LEN_RST;
            gam_length_reg <= GAM_LEN_RST;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_WAIT_TIME:  wait_time_reg  <= cfg_wdata;
                REG_CLI_WINDOW: cli_window_reg <= cfg_wdata;
                REG_GPS_LENGTH: gps_length_reg <= cfg_wdata[7:0];
                REG_EAM_LENGTH: eam_length_reg <= cfg_wdata[7:0];
                REG_GAM_LENGTH: gam_length_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        is_idle   = 1'b0;
        is_req    = 1'b0;
        is_wait   = 1'b0;
        sen       = SENSOR_GPS;
        addr_byte = ADDR_GPS;
        resp_len  = gps_length_reg;
        case (phase_reg)
            PH_REQ_GPS:  begin is_req = 1'b1; end
            PH_WAIT_GPS: begin is_wait = 1'b1; end
            PH_REQ_EAM: begin
                is_req = 1'b1; sen = SENSOR_EAM; addr_byte = ADDR_EAM;
            end
            PH_WAIT_EAM: begin
                is_wait = 1'b1; sen = SENSOR_EAM; resp_len = eam_length_reg;
            end
            PH_REQ_GAM: begin
                is_req = 1'b1; sen = SENSOR_GAM; addr_byte = ADDR_GAM;
            end
            PH_WAIT_GAM: begin
                is_wait = 1'b1; sen = SENSOR_GAM; resp_len = gam_length_reg;
            end
            default:     begin is_idle = 1'b1; end
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        uptime_next   = uptime_reg;
        elapsed_next  = elapsed_reg;
        rx_count_next = rx_count_reg;
        crlf_next     = crlf_reg;
        ok_next       = ok_reg;
        fail_next     = fail_reg;
        font          = 1'b0;
        mv_n          = 2'd0;
        mv0           = '0;
        mv1           = '0;

        if (!is_byte) begin
            if (uptime_reg != 16'hffff) uptime_next = uptime_reg + 16'd1;
            if (elapsed_reg != 16'hffff) elapsed_next = elapsed_reg + 16'd1;
        end else if (is_idle) begin
            if (uptime_reg < cli_window_reg) begin
                if (s_tdata == CHAR_LF || s_tdata == CHAR_CR) begin
                    crlf_next = crlf_reg + 8'd1;
                end else begin
                    crlf_next = 8'd0;
                end
                font = (crlf_next == CRLF_TRIG);
            end
        end else if (is_wait) begin
            if (rx_count_reg != 8'hff) rx_count_next = rx_count_reg + 8'd1;
        end

        if (is_idle) begin
            if (uptime_next >= cli_window_reg) begin
                mv_n         = 2'd1;
                mv0.out_kind = K_SWITCH;
                phase_next   = PH_REQ_GPS;
            end
        end else if (is_req) begin
            if (elapsed_next > wait_time_reg) begin
                elapsed_next  = 16'd0;
                rx_count_next = 8'd0;
                mv_n          = 2'd2;
                mv0.out_kind  = K_SEND;
                mv0.tx_byte   = REQ_BYTE;
                mv0.sensor    = sen;
                mv1.out_kind  = K_SEND;
                mv1.tx_byte   = addr_byte;
                mv1.sensor    = sen;
                phase_next    = phase_t'({phase_reg[5:0], 1'b0});
            end
        end else begin
            if (rx_count_next >= resp_len) begin
                ok_next[sen] = ok_reg[sen] + 16'd1;
                mv_n         = 2'd1;
                mv0.out_kind = K_OK;
                mv0.sensor   = sen;
                mv0.tally    = ok_next[sen];
            end else if (elapsed_next > wait_time_reg) begin
                fail_next[sen] = fail_reg[sen] + 16'd1;
                mv_n           = 2'd1;
                mv0.out_kind   = K_TIMEOUT;
                mv0.sensor     = sen;
                mv0.tally      = fail_next[sen];
            end
            if (mv_n != 2'd0) begin
                phase_next = (phase_reg == PH_WAIT_GAM) ? PH_IDLE
                                                        : phase_t'({phase_reg[5:0], 1'b0});
            end
        end
    end

    always_comb begin
        res0 = mv0;
        res1 = mv1;
        push_n = mv_n;
        if (font) begin
            res0          = '0;
            res0.out_kind = K_FONT;
            res1          = mv0;
            push_n        = mv_n + 2'd1;
        end
        res0.last = (push_n == 2'd1);
        res1.last = 1'b1;
    end

    always_comb begin
        count_next = count_reg;
        if (s_acc) count_next = count_next + (QUEUE_AW+1)'(push_n);
        if (m_acc) count_next = count_next - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            elapsed_reg  <= '0;
            uptime_reg   <= '0;
            rx_count_reg <= '0;
            crlf_reg     <= '0;
            ok_reg       <= '{default: '0};
            fail_reg     <= '{default: '0};
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (s_acc) begin
                phase_reg    <= phase_next;
                elapsed_reg  <= elapsed_next;
                uptime_reg   <= uptime_next;
                rx_count_reg <= rx_count_next;
                crlf_reg     <= crlf_next;
                ok_reg       <= ok_next;
                fail_reg     <= fail_next;
                wr_ptr_reg   <= wr_ptr_reg + QUEUE_AW'(push_n);
            end
            if (m_acc) rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            if (push_n != 2'd0) queue_reg[wr_ptr_reg] <= res0;
            if (push_n == 2'd2) queue_reg[wr_ptr_reg + QUEUE_AW'(1)] <= res1;
        end
    end

    assign m_tdata = {3'b000, queue_reg[rd_ptr_reg].tally, queue_reg[rd_ptr_reg].sensor,
                      queue_reg[rd_ptr_reg].tx_byte, queue_reg[rd_ptr_reg].out_kind};
    assign m_tlast = queue_reg[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_req_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == K_SEND && m_tdata[10:3] == REQ_BYTE) |-> !m_tlast)
        else $error("request byte marked as last result");

    a_request_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_req && phase_next != phase_reg) |=> (elapsed_reg == 16'd0))
        else $error("timer not cleared on request");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= K_SWITCH))
        else $error("result kind out of range");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import tsps_pkg::*;

    typedef struct packed {
        logic       is_byte;
        logic [7:0] data;
    } link_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_wdata = 16'd0;

    link_word_t  pending_words[$];
    link_word_t  next_word;
    result_t     expected_results[$];
    result_t     want;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cnt = 0;
    logic        hold_start = 1'b0;
    int          mismatches = 0;

    // shadow of the sequencer
    logic [15:0] wait_ms = WAIT_TIME_RST;
    logic [15:0] window_ms = CLI_WINDOW_RST;
    logic [7:0]  resp_len[3] = '{GPS_LEN_RST, EAM_LEN_RST, GAM_LEN_RST};
    phase_t      poll_phase = PH_IDLE;
    logic [15:0] elapsed = 16'd0;
    logic [15:0] uptime = 16'd0;
    logic [7:0]  rx_cnt = 8'd0;
    logic [7:0]  crlf_cnt = 8'd0;
    logic [15:0] ok_cnt[3] = '{16'd0, 16'd0, 16'd0};
    logic [15:0] fail_cnt[3] = '{16'd0, 16'd0, 16'd0};

    telemetry_sensor_poll_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [1:0] sensor_of(input phase_t ph);
        case (ph)
            PH_REQ_EAM, PH_WAIT_EAM: return SENSOR_EAM;
            PH_REQ_GAM, PH_WAIT_GAM: return SENSOR_GAM;
            default:                 return SENSOR_GPS;
        endcase
    endfunction

    function automatic phase_t next_phase(input phase_t ph);
        case (ph)
            PH_REQ_GPS:  return PH_WAIT_GPS;
            PH_WAIT_GPS: return PH_REQ_EAM;
            PH_REQ_EAM:  return PH_WAIT_EAM;
            PH_WAIT_EAM: return PH_REQ_GAM;
            PH_REQ_GAM:  return PH_WAIT_GAM;
            default:     return PH_IDLE;
        endcase
    endfunction

    function automatic logic [7:0] addr_of(input logic [1:0] sen);
        case (sen)
            SENSOR_EAM: return ADDR_EAM;
            SENSOR_GAM: return ADDR_GAM;
            default:    return ADDR_GPS;
        endcase
    endfunction

    function automatic result_t make_result(input out_kind_t k, input logic [7:0] tx,
                                            input logic [1:0] sen, input logic [15:0] cnt);
        result_t r;
        r.out_kind = k;
        r.tx_byte  = tx;
        r.sensor   = sen;
        r.tally    = cnt;
        r.last     = 1'b0;
        return r;
    endfunction

    task automatic predict_word(input logic is_byte, input logic [7:0] rx);
        result_t    outs[$];
        logic [1:0] sen;
        sen = sensor_of(poll_phase);
        if (!is_byte) begin
            if (uptime != 16'hffff) uptime = uptime + 16'd1;
            if (elapsed != 16'hffff) elapsed = elapsed + 16'd1;
        end else if (poll_phase == PH_IDLE) begin
            if (uptime < window_ms) begin
                if (rx == CHAR_LF || rx == CHAR_CR) crlf_cnt = crlf_cnt + 8'd1;
                else crlf_cnt = 8'd0;
                if (crlf_cnt == CRLF_TRIG)
                    outs.push_back(make_result(K_FONT, 8'd0, SENSOR_GPS, 16'd0));
            end
        end else if (poll_phase inside {PH_WAIT_GPS, PH_WAIT_EAM, PH_WAIT_GAM}) begin
            if (rx_cnt != 8'hff) rx_cnt = rx_cnt + 8'd1;
        end

        case (poll_phase)
            PH_IDLE: begin
                if (uptime >= window_ms) begin
                    outs.push_back(make_result(K_SWITCH, 8'd0, SENSOR_GPS, 16'd0));
                    poll_phase = PH_REQ_GPS;
                end
            end
            PH_REQ_GPS, PH_REQ_EAM, PH_REQ_GAM: begin
                if (elapsed > wait_ms) begin
                    elapsed = 16'd0;
                    rx_cnt = 8'd0;
                    outs.push_back(make_result(K_SEND, REQ_BYTE, sen, 16'd0));
                    outs.push_back(make_result(K_SEND, addr_of(sen), sen, 16'd0));
                    poll_phase = next_phase(poll_phase);
                end
            end
            default: begin
                // a full response wins over a timeout on the same word
                if (rx_cnt >= resp_len[sen]) begin
                    ok_cnt[sen] = ok_cnt[sen] + 16'd1;
                    outs.push_back(make_result(K_OK, 8'd0, sen, ok_cnt[sen]));
                    poll_phase = next_phase(poll_phase);
                end else if (elapsed > wait_ms) begin
                    fail_cnt[sen] = fail_cnt[sen] + 16'd1;
                    outs.push_back(make_result(K_TIMEOUT, 8'd0, sen, fail_cnt[sen]));
                    poll_phase = next_phase(poll_phase);
                end
            end
        endcase

        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) expected_results.push_back(outs[i]);
    endtask

    task automatic check_field(input string what, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, what, exp_val, act_val);
            mismatches++;
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_word(s_tuser[0], s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_word.is_byte;
                    s_tdata  <= next_word.data;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_start) hold_cnt <= 400;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    // receiver and result check
    always @(posedge aclk) begin
        m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected word, expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_kind", 16'(want.out_kind), 16'(m_tdata[2:0]));
                check_field("tx_byte", 16'(want.tx_byte), 16'(m_tdata[10:3]));
                check_field("sensor", 16'(want.sensor), 16'(m_tdata[12:11]));
                check_field("tally", want.tally, m_tdata[28:13]);
                check_field("pad", 16'd0, 16'(m_tdata[31:29]));
                check_field("tlast", 16'(want.last), 16'(m_tlast));
            end
        end
    end

    task automatic queue_tick();
        link_word_t w;
        w.is_byte = 1'b0;
        w.data = 8'($urandom_range(255));
        pending_words.push_back(w);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        link_word_t w;
        w.is_byte = 1'b1;
        w.data = b;
        pending_words.push_back(w);
    endtask

    task automatic queue_traffic(input int count, input int byte_pct, input int crlf_pct);
        int         run;
        bit         as_bytes;
        logic [7:0] b;
        @(negedge aclk);
        while (count > 0) begin
            as_bytes = ($urandom_range(99) < byte_pct);
            run = $urandom_range(1, 12);
            if (run > count) run = count;
            count -= run;
            repeat (run) begin
                if (as_bytes) begin
                    b = 8'($urandom_range(255));
                    if ($urandom_range(99) < crlf_pct) b = $urandom_range(1) ? CHAR_CR : CHAR_LF;
                    queue_byte(b);
                end else begin
                    queue_tick();
                end
            end
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_WAIT_TIME:  wait_ms = val;
            REG_CLI_WINDOW: window_ms = val;
            REG_GPS_LENGTH: resp_len[SENSOR_GPS] = val[7:0];
            REG_EAM_LENGTH: resp_len[SENSOR_EAM] = val[7:0];
            REG_GAM_LENGTH: resp_len[SENSOR_GAM] = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] wt, input logic [15:0] win,
                            input logic [7:0] gps, input logic [7:0] eam, input logic [7:0] gam);
        write_reg(REG_WAIT_TIME, wt);
        write_reg(REG_CLI_WINDOW, win);
        write_reg(REG_GPS_LENGTH, {8'd0, gps});
        write_reg(REG_EAM_LENGTH, {8'd0, eam});
        write_reg(REG_GAM_LENGTH, {8'd0, gam});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input int send_idle, input int recv_stall);
        @(posedge aclk);
        idle_pct  <= send_idle;
        stall_pct <= recv_stall;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // CR/LF detection inside the window, default registers
        @(negedge aclk);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_byte(8'h41);
        queue_byte(CHAR_LF);
        queue_byte(CHAR_LF);
        queue_byte(CHAR_CR);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_tick();
        queue_tick();
        drain();

        // zero window and zero wait: switch, zero-length ok, one-byte ok, timeout
        set_regs(16'd0, 16'd0, 8'd0, 8'd1, 8'd2);
        @(negedge aclk);
        queue_tick();
        queue_byte(8'h55);
        queue_tick();
        queue_tick();
        queue_byte(8'haa);
        queue_byte(8'h01);
        queue_tick();
        queue_byte(8'hfe);
        queue_tick();
        queue_byte(CHAR_CR);
        queue_tick();
        drain();

        // receiver held off while words keep coming
        set_regs(16'd3, 16'd0, 8'd2, 8'd3, 8'd1);
        set_mode(0, 0);
        queue_traffic(200, 55, 10);
        @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        drain();

        set_regs(16'd0, 16'd0, 8'd1, 8'd1, 8'd1);
        set_mode(63, 0);
        queue_traffic(150, 50, 10);
        drain();

        set_regs(16'd5, 16'd0, 8'd4, 8'd6, 8'd3);
        set_mode(0, 63);
        queue_traffic(180, 60, 10);
        drain();

        // window reopened: CR/LF runs once the cycle is back in idle
        set_regs(16'd2, 16'hffff, 8'd2, 8'd2, 8'd2);
        set_mode(20, 20);
        queue_traffic(150, 75, 70);
        drain();

        // longest wait: the sequencer can no longer time out or request
        set_regs(16'hffff, 16'd0, 8'd3, 8'd255, 8'd3);
        set_mode(0, 0);
        queue_traffic(60, 80, 5);
        drain();

        // longest responses
        set_regs(16'd1, 16'd0, 8'd255, 8'd255, 8'd255);
        set_mode(20, 20);
        @(negedge aclk);
        repeat (3) queue_tick();
        repeat (256) queue_byte(8'($urandom_range(255)));
        queue_traffic(30, 50, 5);
        drain();

        repeat (3) begin
            set_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 3)),
                     8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
                     8'($urandom_range(1, 5)));
            set_mode(20, 20);
            queue_traffic(90, 55, 15);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tsps_pkg.sv
rtl/core/telemetry_sensor_poll_sequencer.sv
test/testbench.sv
